// File: hw/rtl/gte_matrix_vector_transform_macros.svh
// Assertion macros for the matrix-vector transform block.
// Clock and reset are taken from the signals named clock and reset in the using module.
`ifndef GTE_MATRIX_VECTOR_TRANSFORM_MACROS_SVH
`define GTE_MATRIX_VECTOR_TRANSFORM_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: cons must hold in any cycle where ante holds.
`define GMVT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gmvt same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define GMVT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gmvt next-cycle check failed");

`else

`define GMVT_ASSERT_SAME(label, ante, cons)
`define GMVT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/gmvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gmvt_pkg;

   localparam int WORD_W     = 32;
   localparam int HALF_W     = 16;
   localparam int REG_IDX_W  = 5;
   localparam int CTRL_DEPTH = 21;
   localparam int DATA_DEPTH = 12;
   localparam int DATA_IDX_W = 4;
   localparam int FRAC_BITS  = 12;
   // translation << 12 needs 44 bits, plus headroom for three 32-bit products
   localparam int SUM_W      = 46;

   localparam logic signed [WORD_W-1:0] IR_MAX = 32'sd32767;
   localparam logic signed [WORD_W-1:0] IR_MIN = -32'sd32768;

   // data store slots that hold IR1..IR3
   localparam logic [DATA_IDX_W-1:0] IR1_SLOT = 4'd9;
   localparam logic [DATA_IDX_W-1:0] IR2_SLOT = 4'd10;
   localparam logic [DATA_IDX_W-1:0] IR3_SLOT = 4'd11;

   typedef enum logic [1:0] {
      OP_WR_CTRL = 2'd0,
      OP_WR_DATA = 2'd1,
      OP_XFORM   = 2'd2
   } opcode_type;

   typedef struct packed {
      logic signed [HALF_W-1:0] ir;
      logic                     clamped;
   } sat_type;

   // translation * 4096 + dot product of one matrix row with the vector
   function automatic logic signed [SUM_W-1:0] row_sum(
      input logic signed [WORD_W-1:0] tr,
      input logic signed [HALF_W-1:0] a0,
      input logic signed [HALF_W-1:0] a1,
      input logic signed [HALF_W-1:0] a2,
      input logic signed [HALF_W-1:0] v0,
      input logic signed [HALF_W-1:0] v1,
      input logic signed [HALF_W-1:0] v2
   );
      logic signed [WORD_W-1:0] p0;
      logic signed [WORD_W-1:0] p1;
      logic signed [WORD_W-1:0] p2;
      logic signed [WORD_W+FRAC_BITS-1:0] trs;
      p0  = a0 * v0;
      p1  = a1 * v1;
      p2  = a2 * v2;
      trs = $signed({tr, {FRAC_BITS{1'b0}}});
      return SUM_W'(trs) + SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
   endfunction

   function automatic sat_type clamp_ir(
      input logic signed [WORD_W-1:0] mac,
      input logic                     floor_zero
   );
      logic signed [WORD_W-1:0] lo;
      sat_type                  res;
      lo = floor_zero ? '0 : IR_MIN;
      if (mac < lo) begin
         res.ir      = HALF_W'(lo);
         res.clamped = 1'b1;
      end else if (mac > IR_MAX) begin
         res.ir      = HALF_W'(IR_MAX);
         res.clamped = 1'b1;
      end else begin
         res.ir      = mac[HALF_W-1:0];
         res.clamped = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gte_matrix_vector_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// Matrix-vector transform slice of a geometry coprocessor.
// Request channel (req_*): one transfer per item. Opcode OP_WR_CTRL writes a control
// word (matrices, translations), OP_WR_DATA a data word (vertices, IR1-3), OP_XFORM
// runs the transform. Writes and the unused opcode produce no response.
// Response channel (rsp_*): one transfer per transform carrying MAC1-3, IR1-3 and
// the clamp flags. Saturated IR1-3 are written back into data slots 9-11.
// Pipeline: an item is captured in the input register and executed from it; a
// transform's response is then held in the response register.
// Throughput: one item per cycle while req_stall is low, writes and transforms mixed
// freely; the nine 16x16 products, row adders and clamps sit in one stage between
// the input register and the response register, and the store write-back closes in
// that same cycle, so a transform can consume the IR of the one right before it.
// Stall: when rsp_stall holds a pending response, a transform in the input
// register waits and req_stall goes high; register writes still drain.
// Reset (synchronous, active high): both stores clear to zero, both stages empty.
module gte_matrix_vector_transform
   import gmvt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_opcode,
   input  wire logic [REG_IDX_W-1:0]     req_reg_index,
   input  wire logic [WORD_W-1:0]        req_write_value,
   input  wire logic                     req_clamp_low_zero,
   input  wire logic [1:0]               req_matrix_sel,
   input  wire logic [1:0]               req_vector_sel,
   input  wire logic [1:0]               req_translation_sel,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [WORD_W-1:0]      rsp_mac_x,
   output logic signed [WORD_W-1:0]      rsp_mac_y,
   output logic signed [WORD_W-1:0]      rsp_mac_z,
   output logic signed [HALF_W-1:0]      rsp_ir_x,
   output logic signed [HALF_W-1:0]      rsp_ir_y,
   output logic signed [HALF_W-1:0]      rsp_ir_z,
   output logic [2:0]                    rsp_clamp_flags
);

`include "gte_matrix_vector_transform_macros.svh"

   // ---------------------------------------------------------------- input register
   logic                 s1_valid_ff;
   opcode_type           s1_op_ff;
   logic [REG_IDX_W-1:0] s1_idx_ff;
   logic [WORD_W-1:0]    s1_value_ff;
   logic                 s1_floor_zero_ff;
   logic [1:0]           s1_mtx_ff;
   logic [1:0]           s1_vec_ff;
   logic [1:0]           s1_trn_ff;

   // ---------------------------------------------------------------- stores
   logic [WORD_W-1:0] ctrl_ff [CTRL_DEPTH];
   logic [WORD_W-1:0] ctrl_in [CTRL_DEPTH];
   logic [WORD_W-1:0] data_ff [DATA_DEPTH];
   logic [WORD_W-1:0] data_in [DATA_DEPTH];

   // ---------------------------------------------------------------- response register
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_mac_ff [3];
   logic signed [HALF_W-1:0] rsp_ir_ff  [3];
   logic [2:0]               rsp_flags_ff;

   logic out_free;
   logic s1_is_xform;
   logic s1_fire;
   logic xform_fire;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_is_xform = (s1_op_ff == OP_XFORM);
   // writes never wait; a transform waits for room in the response register
   assign s1_fire     = s1_valid_ff && (!s1_is_xform || out_free);
   assign xform_fire  = s1_fire && s1_is_xform;
   assign req_stall   = s1_valid_ff && !s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_op_ff         <= opcode_type'(req_opcode);
         s1_idx_ff        <= req_reg_index;
         s1_value_ff      <= req_write_value;
         s1_floor_zero_ff <= req_clamp_low_zero;
         s1_mtx_ff        <= req_matrix_sel;
         s1_vec_ff        <= req_vector_sel;
         s1_trn_ff        <= req_translation_sel;
      end
   end

   // ---------------------------------------------------------------- operand select
   logic [WORD_W-1:0]        mw [5];      // five packed matrix words
   logic signed [HALF_W-1:0] m  [9];
   logic [WORD_W-1:0]        vec_xy;
   logic [WORD_W-1:0]        vec_z;
   logic signed [HALF_W-1:0] v  [3];
   logic signed [WORD_W-1:0] tr [3];

   always_comb begin
      case (s1_mtx_ff)
         2'd0: begin   // rotation
            mw[0] = ctrl_ff[0];
            mw[1] = ctrl_ff[1];
            mw[2] = ctrl_ff[2];
            mw[3] = ctrl_ff[3];
            mw[4] = ctrl_ff[4];
         end
         2'd1: begin   // light
            mw[0] = ctrl_ff[8];
            mw[1] = ctrl_ff[9];
            mw[2] = ctrl_ff[10];
            mw[3] = ctrl_ff[11];
            mw[4] = ctrl_ff[12];
         end
         default: begin   // colour, both codes
            mw[0] = ctrl_ff[16];
            mw[1] = ctrl_ff[17];
            mw[2] = ctrl_ff[18];
            mw[3] = ctrl_ff[19];
            mw[4] = ctrl_ff[20];
         end
      endcase
   end

   // low half first: m11 m12 | m13 m21 | m22 m23 | m31 m32 | m33
   assign m[0] = mw[0][HALF_W-1:0];
   assign m[1] = mw[0][WORD_W-1:HALF_W];
   assign m[2] = mw[1][HALF_W-1:0];
   assign m[3] = mw[1][WORD_W-1:HALF_W];
   assign m[4] = mw[2][HALF_W-1:0];
   assign m[5] = mw[2][WORD_W-1:HALF_W];
   assign m[6] = mw[3][HALF_W-1:0];
   assign m[7] = mw[3][WORD_W-1:HALF_W];
   assign m[8] = mw[4][HALF_W-1:0];

   always_comb begin
      vec_xy = data_ff[0];
      vec_z  = data_ff[1];
      case (s1_vec_ff)
         2'd0: begin
            vec_xy = data_ff[0];
            vec_z  = data_ff[1];
         end
         2'd1: begin
            vec_xy = data_ff[2];
            vec_z  = data_ff[3];
         end
         2'd2: begin
            vec_xy = data_ff[4];
            vec_z  = data_ff[5];
         end
         default: begin
         end
      endcase
      if (s1_vec_ff == 2'd3) begin   // IR vector
         v[0] = data_ff[IR1_SLOT][HALF_W-1:0];
         v[1] = data_ff[IR2_SLOT][HALF_W-1:0];
         v[2] = data_ff[IR3_SLOT][HALF_W-1:0];
      end else begin
         v[0] = vec_xy[HALF_W-1:0];
         v[1] = vec_xy[WORD_W-1:HALF_W];
         v[2] = vec_z[HALF_W-1:0];
      end
   end

   always_comb begin
      case (s1_trn_ff)
         2'd0: begin   // TR
            tr[0] = ctrl_ff[5];
            tr[1] = ctrl_ff[6];
            tr[2] = ctrl_ff[7];
         end
         2'd1, 2'd2: begin   // background
            tr[0] = ctrl_ff[13];
            tr[1] = ctrl_ff[14];
            tr[2] = ctrl_ff[15];
         end
         default: begin   // no translation
            tr[0] = '0;
            tr[1] = '0;
            tr[2] = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   logic signed [SUM_W-1:0]  sum [3];
   logic signed [WORD_W-1:0] mac [3];
   sat_type                  sat [3];

   assign sum[0] = row_sum(tr[0], m[0], m[1], m[2], v[0], v[1], v[2]);
   assign sum[1] = row_sum(tr[1], m[3], m[4], m[5], v[0], v[1], v[2]);
   assign sum[2] = row_sum(tr[2], m[6], m[7], m[8], v[0], v[1], v[2]);

   // arithmetic >> 12, then wrap to 32 bits
   assign mac[0] = sum[0][FRAC_BITS+WORD_W-1:FRAC_BITS];
   assign mac[1] = sum[1][FRAC_BITS+WORD_W-1:FRAC_BITS];
   assign mac[2] = sum[2][FRAC_BITS+WORD_W-1:FRAC_BITS];

   assign sat[0] = clamp_ir(mac[0], s1_floor_zero_ff);
   assign sat[1] = clamp_ir(mac[1], s1_floor_zero_ff);
   assign sat[2] = clamp_ir(mac[2], s1_floor_zero_ff);

   // ---------------------------------------------------------------- store update
   always_comb begin
      ctrl_in = ctrl_ff;
      data_in = data_ff;
      if (s1_fire) begin
         case (s1_op_ff)
            OP_WR_CTRL: begin
               if (s1_idx_ff < REG_IDX_W'(CTRL_DEPTH)) begin
                  ctrl_in[s1_idx_ff] = s1_value_ff;
               end
            end
            OP_WR_DATA: begin
               if (s1_idx_ff < REG_IDX_W'(DATA_DEPTH)) begin
                  data_in[s1_idx_ff[DATA_IDX_W-1:0]] = s1_value_ff;
               end
            end
            OP_XFORM: begin   // IR write-back, sign extended
               data_in[IR1_SLOT] = WORD_W'(sat[0].ir);
               data_in[IR2_SLOT] = WORD_W'(sat[1].ir);
               data_in[IR3_SLOT] = WORD_W'(sat[2].ir);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '{default: '0};
         data_ff <= '{default: '0};
      end else begin
         ctrl_ff <= ctrl_in;
         data_ff <= data_in;
      end
   end

   // ---------------------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (xform_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (xform_fire) begin
         rsp_mac_ff[0] <= mac[0];
         rsp_mac_ff[1] <= mac[1];
         rsp_mac_ff[2] <= mac[2];
         rsp_ir_ff[0]  <= sat[0].ir;
         rsp_ir_ff[1]  <= sat[1].ir;
         rsp_ir_ff[2]  <= sat[2].ir;
         rsp_flags_ff  <= {sat[0].clamped, sat[1].clamped, sat[2].clamped};
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mac_x       = rsp_mac_ff[0];
   assign rsp_mac_y       = rsp_mac_ff[1];
   assign rsp_mac_z       = rsp_mac_ff[2];
   assign rsp_ir_x        = rsp_ir_ff[0];
   assign rsp_ir_y        = rsp_ir_ff[1];
   assign rsp_ir_z        = rsp_ir_ff[2];
   assign rsp_clamp_flags = rsp_flags_ff;

   // ---------------------------------------------------------------- checks
   // only a transform waiting on a full, stalled response register holds the input
   `GMVT_ASSERT_SAME(a_stall_cause, req_stall,
      s1_valid_ff && s1_is_xform && rsp_valid_ff && rsp_stall)
   // every executed transform shows up as a response
   `GMVT_ASSERT_NEXT(a_xform_rsp, xform_fire, rsp_valid_ff)
   // a write that leaves the response register free produces nothing
   `GMVT_ASSERT_NEXT(a_write_silent, s1_fire && !s1_is_xform && out_free, !rsp_valid_ff)
   // the IR1 and IR3 written back match the IR reported
   `GMVT_ASSERT_NEXT(a_ir_writeback, xform_fire,
      data_ff[IR1_SLOT] == WORD_W'(rsp_ir_ff[0]) && data_ff[IR3_SLOT] == WORD_W'(rsp_ir_ff[2]))
   // an unclamped IR1 is the low half of MAC1
   `GMVT_ASSERT_SAME(a_unclamped_ir, rsp_valid_ff && !rsp_flags_ff[2],
      rsp_ir_ff[0] == rsp_mac_ff[0][HALF_W-1:0])

endmodule

`default_nettype wire
